FILE: src/symmetric_pair_table_defines.svh
// ---------------------------------------------------------------------------
// symmetric_pair_table_defines.svh
// Assertion macros used by the symmetric pair table datapath.
// ---------------------------------------------------------------------------
`ifndef SYMMETRIC_PAIR_TABLE_DEFINES_SVH
`define SYMMETRIC_PAIR_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/spt_pkg.sv
// ---------------------------------------------------------------------------
// spt_pkg
// Constants, command/status bundles and helpers for the pair table.
// ---------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned ELEM_BITS = 32;
  localparam int unsigned DEPTH     = MAX_NODES * (MAX_NODES + 1) / 2;
  localparam int unsigned IDX_W     = $clog2(MAX_NODES);
  localparam int unsigned SLOT_W    = $clog2(DEPTH);
  localparam int unsigned END_W     = SLOT_W + 1;
  localparam int unsigned CNT_W     = $clog2(SLOT_W + 1);
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned OUT_W     = 32;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);
  localparam logic             REQ_INSERT = 1'b0;
  localparam logic             REQ_GET    = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture the item
    logic calc_slot;   // packed triangular slot
    logic div_start;   // slot / bucket size
    logic calc_base;   // first slot of the bucket
    logic mem_rd;      // read entry and bucket flag
    logic calc_end;    // end of the bucket range
    logic ptr_first;   // load sweep pointer with the bucket base
    logic clr_init;    // post-reset clearing pass, one entry
    logic clr_bucket;  // new-bucket clearing, one entry
    logic set_alloc;   // mark the bucket allocated
    logic wr_slot;     // store the element
    logic respond;     // launch the result
  } spt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
    logic init_last;
    logic sweep_last;
    logic req_get;
    logic alloc_hit;
  } spt_sts_t;

  // Clamp the configured bucket size into 1 .. DEPTH.
  function automatic logic [SLOT_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
    logic [SLOT_W-1:0] res;
    if (cfg == '0) begin
      res = SLOT_W'(1);
    end else if (32'(cfg) > DEPTH) begin
      res = SLOT_W'(DEPTH);
    end else begin
      res = SLOT_W'(cfg);
    end
    return res;
  endfunction

endpackage

FILE: src/spt_divider.sv
// ---------------------------------------------------------------------------
// spt_divider
// Restoring divider, one quotient bit per cycle; quotient held until restart.
// ---------------------------------------------------------------------------
module spt_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [spt_pkg::SLOT_W-1:0] dividend,
  input  logic [spt_pkg::SLOT_W-1:0] divisor,
  output logic [spt_pkg::SLOT_W-1:0] quotient,
  output logic                      done
);
  import spt_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SLOT_W-1:0] rem_r;
  logic [SLOT_W-1:0] q_r;

  logic [SLOT_W:0]   shifted;
  logic [SLOT_W+1:0] diff;
  logic              ge;
  logic [SLOT_W-1:0] rem_nxt;
  logic [SLOT_W-1:0] q_nxt;

  always_comb begin
    shifted = {rem_r, q_r[SLOT_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    ge      = ~diff[SLOT_W+1];
    rem_nxt = ge ? diff[SLOT_W-1:0] : shifted[SLOT_W-1:0];
    q_nxt   = {q_r[SLOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(SLOT_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

FILE: src/spt_datapath.sv
// ---------------------------------------------------------------------------
// spt_datapath
// Slot arithmetic, bucket divider, entry and bucket memories, result register.
// ---------------------------------------------------------------------------
`include "symmetric_pair_table_defines.svh"

module spt_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spt_pkg::spt_cmd_t             cmd,
  output spt_pkg::spt_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [spt_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_req_type,
  input  logic [spt_pkg::IDX_W-1:0]     in_index_a,
  input  logic [spt_pkg::IDX_W-1:0]     in_index_b,
  input  logic [spt_pkg::ELEM_BITS-1:0] in_element_data,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [spt_pkg::OUT_W-1:0]     out_read_data
);
  import spt_pkg::*;

  logic [CFG_W-1:0]     bucket_size_r;
  logic                 req_r;
  logic [IDX_W-1:0]     a_r;
  logic [IDX_W-1:0]     b_r;
  logic [ELEM_BITS-1:0] elem_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    first_r;
  logic [END_W-1:0]     end_r;
  logic [SLOT_W-1:0]    ptr_r;
  logic [ELEM_BITS:0]   store_q_r;
  logic                 alloc_q_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [OUT_W-1:0]     out_data_r;

  logic [ELEM_BITS:0]   store_mem [DEPTH];
  logic                 alloc_mem [DEPTH];

  logic [SLOT_W-1:0]    size;
  logic [SLOT_W-1:0]    bucket;
  logic                 div_done;
  logic [IDX_W-1:0]     n_big;
  logic [IDX_W-1:0]     m_small;
  logic [2*IDX_W:0]     tri_prod;
  logic [2*IDX_W:0]     slot_sum;
  logic [2*SLOT_W-1:0]  base_prod;
  logic [END_W-1:0]     end_sum;
  logic                 st_we;
  logic [SLOT_W-1:0]    st_addr;
  logic [ELEM_BITS:0]   st_wdata;
  logic                 al_we;
  logic [SLOT_W-1:0]    al_addr;
  logic                 hit_data;

  assign size = eff_size(bucket_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      bucket_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      a_r    <= in_index_a;
      b_r    <= in_index_b;
      elem_r <= in_element_data;
    end
  end

  // n*(n+1)/2 + m with n the larger index
  always_comb begin
    n_big    = (a_r >= b_r) ? a_r : b_r;
    m_small  = (a_r >= b_r) ? b_r : a_r;
    tri_prod = (2*IDX_W+1)'({1'b0, n_big} + 1'b1) * (2*IDX_W+1)'(n_big);
    slot_sum = (tri_prod >> 1) + (2*IDX_W+1)'(m_small);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_slot) begin
      slot_r <= slot_sum[SLOT_W-1:0];
    end
  end

  spt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (slot_r),
    .divisor  (size),
    .quotient (bucket),
    .done     (div_done)
  );

  assign base_prod = bucket * size;
  assign end_sum   = {1'b0, first_r} + {1'b0, size};

  always_ff @(posedge clk) begin
    if (cmd.calc_base) begin
      first_r <= base_prod[SLOT_W-1:0];
    end
    if (cmd.calc_end) begin
      end_r <= (32'(end_sum) > DEPTH) ? END_W'(DEPTH) : end_sum;
    end
  end

  // Sweep pointer shared by the post-reset pass and bucket clearing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_first) begin
      ptr_r <= first_r;
    end else if (cmd.clr_init || cmd.clr_bucket) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  always_comb begin
    st_we    = cmd.clr_init | cmd.clr_bucket | cmd.wr_slot;
    st_addr  = cmd.wr_slot ? slot_r : ptr_r;
    st_wdata = cmd.wr_slot ? {1'b1, elem_r} : '0;
    al_we    = cmd.clr_init | cmd.set_alloc;
    al_addr  = cmd.set_alloc ? bucket : ptr_r;
  end

  // Entry store: written flag on top of the element
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_addr] <= st_wdata;
    end
    if (cmd.mem_rd) begin
      store_q_r <= store_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (al_we) begin
      alloc_mem[al_addr] <= cmd.set_alloc;
    end
    if (cmd.mem_rd) begin
      alloc_q_r <= alloc_mem[bucket];
    end
  end

  assign hit_data = (req_r == REQ_GET) && alloc_q_r && store_q_r[ELEM_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_found_r <= (req_r == REQ_GET) ? alloc_q_r : 1'b1;
      out_data_r  <= hit_data ? OUT_W'(store_q_r[ELEM_BITS-1:0]) : '0;
    end
  end

  always_comb begin
    sts.div_done   = div_done;
    sts.init_last  = (ptr_r == SLOT_W'(DEPTH - 1));
    sts.sweep_last = (({1'b0, ptr_r} + 1'b1) == end_r);
    sts.req_get    = (req_r == REQ_GET);
    sts.alloc_hit  = alloc_q_r;
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_read_data = out_data_r;

  `SPT_ASSERT_IMP(a_slot_in_bucket, cmd.wr_slot, (slot_r >= first_r) && ({1'b0, slot_r} < end_r), "element written outside its bucket range")
  `SPT_ASSERT_IMP(a_div_exact, div_done, ((2*SLOT_W)'(bucket) * (2*SLOT_W)'(size) <= (2*SLOT_W)'(slot_r)) && ((2*SLOT_W)'(bucket + 1'b1) * (2*SLOT_W)'(size) > (2*SLOT_W)'(slot_r)), "bucket quotient wrong")
  `SPT_ASSERT_NXT(a_data_needs_found, cmd.respond, out_found_r || (out_data_r == '0), "data returned without found")

endmodule

FILE: src/spt_ctrl.sv
// ---------------------------------------------------------------------------
// spt_ctrl
// Sequencer: clearing pass, slot and bucket computation, lookup, update.
// ---------------------------------------------------------------------------
module spt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output spt_pkg::spt_cmd_t cmd,
  input  spt_pkg::spt_sts_t sts
);
  import spt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_DSTART,
    ST_DWAIT,
    ST_BASE,
    ST_LOOK,
    ST_SWEEP,
    ST_WRITE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_init = 1'b1;
        if (sts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SLOT;
        end
      end
      ST_SLOT: begin
        cmd.calc_slot = 1'b1;
        state_nxt     = ST_DSTART;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts.div_done) state_nxt = ST_BASE;
      end
      ST_BASE: begin
        cmd.calc_base = 1'b1;
        cmd.mem_rd    = 1'b1;
        state_nxt     = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.calc_end  = 1'b1;
        cmd.ptr_first = 1'b1;
        if (sts.req_get) begin
          cmd.respond = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.alloc_hit) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.set_alloc = 1'b1;
          state_nxt     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.clr_bucket = 1'b1;
        if (sts.sweep_last) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr_slot = 1'b1;
        cmd.respond = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: src/symmetric_pair_table.sv
// ---------------------------------------------------------------------------
// symmetric_pair_table
// Pair-keyed table in packed lower-triangular order with lazy buckets.
// ---------------------------------------------------------------------------
// Sequence: the item is loaded and its slot computed, then divided by the
//   bucket size in the bit-serial divider. A get responds from the lookup;
//   an insert writes after it, first clearing the bucket's entries one a
//   cycle if the lookup finds the bucket unallocated.
// Only one item is in flight; busy is low with the strobe.
// Reset: a flag clearing pass over every entry, busy high; cfg writes taken.
module symmetric_pair_table (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [spt_pkg::IDX_W-1:0]     in_index_a,
  input  logic [spt_pkg::IDX_W-1:0]     in_index_b,
  input  logic [spt_pkg::ELEM_BITS-1:0] in_element_data,
  // result channel, one-cycle strobe
  output logic                          out_valid,
  output logic                          out_found,
  output logic [spt_pkg::OUT_W-1:0]     out_read_data,
  // bucket size register
  input  logic                          cfg_we,
  input  logic [spt_pkg::CFG_W-1:0]     cfg_data
);
  import spt_pkg::*;

  spt_cmd_t cmd;
  spt_sts_t sts;

  // Sequencer: owns busy and drives one command bundle per cycle
  spt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Datapath: the item, slot maths, divider, memories and result register
  spt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_req_type     (in_req_type),
    .in_index_a      (in_index_a),
    .in_index_b      (in_index_b),
    .in_element_data (in_element_data),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_read_data   (out_read_data)
  );

endmodule
